### hw/rtl/rclfp_pkg.sv
// rclfp_pkg: shared types and constants for the rc link frame parser.
// Used by rclfp_store, rclfp_unpack and rc_link_frame_parser. No dependencies.
package rclfp_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned CH_W      = 11;
  localparam int unsigned CH_IDX_W  = 4;
  localparam int unsigned CNT32_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  // Byte counter covers a full store of up to 64 bytes
  localparam int unsigned BCNT_W    = 7;
  // Bit accumulator: up to 10 leftover bits plus one fresh byte
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned ACC_CNT_W = 5;

  // First store byte that carries channel bits
  localparam int unsigned FIRST_CH_BYTE = 3;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hC8;
  localparam logic [LEN_W-1:0]  CHFL_RESET   = 6'd24;
  localparam logic [LEN_W-1:0]  MAXLEN_RESET = 6'd48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHFL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 2'd2;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // One decoded channel handed from the unpacker to the output register
  typedef struct packed {
    logic                valid;
    logic [CH_IDX_W-1:0] index;
    logic [CH_W-1:0]     value;
    logic                last;
  } ch_emit_t;

endpackage

### hw/rtl/rc_link_frame_parser.sv
// rc_link_frame_parser: serial byte frame parser with channel unpacking.
// A tick result is registered in the output register when its transfer is taken.
// A channel frame is read back from the store byte by byte, each byte fetched and then merged,
// and each channel is handed out in turn as the output slot frees, while input is held off.
// A store overflow starts a clearing sweep that zeroes every store address, with input held off.
// Reset (async, active low) returns to hunting and clears counters; store contents are undefined.
module rc_link_frame_parser #(
  parameter int unsigned BUF_DEPTH    = 64,
  parameter int unsigned NUM_CHANNELS = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [rclfp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rclfp_pkg::BYTE_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_op_i,
  input  logic [rclfp_pkg::BYTE_W-1:0]    in_data_byte_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            out_kind_o,
  output logic [rclfp_pkg::CH_IDX_W-1:0]  out_channel_index_o,
  output logic [rclfp_pkg::CH_W-1:0]      out_channel_value_o,
  output logic                            out_last_o,
  output logic                            out_link_active_o,
  output logic [rclfp_pkg::CNT32_W-1:0]   out_resync_errors_o
);
  import rclfp_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_COLLECT
  } phase_e;

  // Configuration registers
  logic [BYTE_W-1:0] sync_q;
  logic [LEN_W-1:0]  chfl_q;
  logic [LEN_W-1:0]  maxlen_q;

  // Parser state
  phase_e             phase_q, phase_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CNT32_W-1:0] fsince_q, fsince_d;
  logic               active_q, active_d;
  logic [CNT32_W-1:0] ovf_q, ovf_d;
  logic               sweep_q;
  logic [AW-1:0]      sweep_addr_q;
  logic               sweep_start;

  // Store and unpacker wiring
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              unpack_start;
  logic              unpack_busy;
  ch_emit_t          emit;

  // Output register
  logic                out_valid_q;
  logic                out_kind_q;
  logic [CH_IDX_W-1:0] out_index_q;
  logic [CH_W-1:0]     out_value_q;
  logic                out_last_q;
  logic                out_active_q;
  logic [CNT32_W-1:0]  out_ovf_q;

  logic slot_free;
  logic in_xfer;
  logic byte_xfer;
  logic tick_xfer;
  logic [BCNT_W-1:0] bcnt_inc;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = !sweep_q && !unpack_busy && ((in_op_i == OP_BYTE) || slot_free);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign byte_xfer  = in_xfer && (in_op_i == OP_BYTE);
  assign tick_xfer  = in_xfer && (in_op_i == OP_TICK);
  assign bcnt_inc   = bcnt_q + BCNT_W'(1);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= SYNC_RESET;
      chfl_q   <= CHFL_RESET;
      maxlen_q <= MAXLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SYNC:   sync_q   <= cfg_wdata_i;
        CFG_CHFL:   chfl_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_MAXLEN: maxlen_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame parsing: next state and store write
  always_comb begin
    phase_e ph;
    ph           = phase_q;
    phase_d      = phase_q;
    bcnt_d       = bcnt_q;
    len_d        = len_q;
    fsince_d     = fsince_q;
    active_d     = active_q;
    ovf_d        = ovf_q;
    sweep_start  = 1'b0;
    unpack_start = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = sweep_addr_q;
    wr_data      = in_data_byte_i;
    if (sweep_q) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end else if (tick_xfer) begin
      if (fsince_q == '0) begin
        active_d = 1'b0;
      end else begin
        fsince_d = '0;
      end
    end else if (byte_xfer) begin
      // full store while collecting: count, clear, rehandle byte as hunting
      if ((phase_q == PH_COLLECT) && (bcnt_q >= BCNT_W'(BUF_DEPTH))) begin
        ovf_d       = ovf_q + CNT32_W'(1);
        sweep_start = 1'b1;
        ph          = PH_HUNT;
      end
      case (ph)
        PH_HUNT: begin
          if (in_data_byte_i == sync_q) begin
            wr_en   = !sweep_start;
            wr_addr = AW'(0);
            bcnt_d  = BCNT_W'(1);
            phase_d = PH_LEN;
          end else begin
            bcnt_d  = '0;
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (in_data_byte_i > {{(BYTE_W-LEN_W){1'b0}}, maxlen_q}) begin
            bcnt_d  = '0;
            phase_d = PH_HUNT;
          end else begin
            len_d   = in_data_byte_i[LEN_W-1:0];
            wr_en   = 1'b1;
            wr_addr = AW'(1);
            bcnt_d  = BCNT_W'(2);
            phase_d = PH_COLLECT;
          end
        end
        PH_COLLECT: begin
          wr_en   = 1'b1;
          wr_addr = bcnt_q[AW-1:0];
          if (bcnt_inc >= (BCNT_W'(len_q) + BCNT_W'(1))) begin
            bcnt_d  = '0;
            phase_d = PH_HUNT;
            if (len_q == chfl_q) begin
              fsince_d     = fsince_q + CNT32_W'(1);
              active_d     = 1'b1;
              unpack_start = 1'b1;
            end
          end else begin
            bcnt_d  = bcnt_inc;
            phase_d = PH_COLLECT;
          end
        end
        default: begin
          bcnt_d  = '0;
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // Parser state and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      bcnt_q       <= '0;
      len_q        <= '0;
      fsince_q     <= '0;
      active_q     <= 1'b0;
      ovf_q        <= '0;
      sweep_q      <= 1'b0;
      sweep_addr_q <= '0;
    end else begin
      phase_q  <= phase_d;
      bcnt_q   <= bcnt_d;
      len_q    <= len_d;
      fsince_q <= fsince_d;
      active_q <= active_d;
      ovf_q    <= ovf_d;
      if (sweep_start) begin
        sweep_q      <= 1'b1;
        sweep_addr_q <= '0;
      end else if (sweep_q) begin
        sweep_addr_q <= sweep_addr_q + AW'(1);
        if (sweep_addr_q == AW'(BUF_DEPTH - 1)) begin
          sweep_q <= 1'b0;
        end
      end
    end
  end

  rclfp_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rclfp_unpack #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (AW)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (unpack_start),
    .slot_free_i (slot_free),
    .busy_o      (unpack_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .emit_o      (emit)
  );

  // Output register: tick status or one decoded channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_xfer || emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      out_kind_q   <= KIND_TICK;
      out_index_q  <= '0;
      out_value_q  <= '0;
      out_last_q   <= 1'b1;
      out_active_q <= active_d;
      out_ovf_q    <= ovf_q;
    end else if (emit.valid) begin
      out_kind_q   <= KIND_CHANNEL;
      out_index_q  <= emit.index;
      out_value_q  <= emit.value;
      out_last_q   <= emit.last;
      out_active_q <= active_q;
      out_ovf_q    <= ovf_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_channel_index_o = out_index_q;
  assign out_channel_value_o = out_value_q;
  assign out_last_o          = out_last_q;
  assign out_link_active_o   = out_active_q;
  assign out_resync_errors_o = out_ovf_q;

  // The store never reads back while it is being written by the parser
  a_no_xfer_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unpack_busy |-> !(byte_xfer && wr_en))
    else $error("parser: store write during channel readback");

  // A channel result flagged last carries the final channel index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_CHANNEL) && out_last_o)
      |-> (out_channel_index_o == CH_IDX_W'(NUM_CHANNELS - 1)))
    else $error("parser: last flag on wrong channel");

  // Every clearing sweep comes with one more overflow count
  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sweep_q) |-> (ovf_q == $past(ovf_q) + CNT32_W'(1)))
    else $error("parser: clearing sweep without overflow count");

  // The byte count never runs past the store
  a_bcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BCNT_W'(BUF_DEPTH))
    else $error("parser: byte count beyond store depth");

endmodule

### hw/rtl/rclfp_store.sv
// rclfp_store: frame byte memory, one write port and one read port.
// Read data is registered. Depends on rclfp_pkg.
module rclfp_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [rclfp_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [rclfp_pkg::BYTE_W-1:0] rd_data_o
);
  import rclfp_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/rclfp_unpack.sv
// rclfp_unpack: reads a finished channel frame from the store byte by byte
// and slices it into 11-bit channels, LSB first. Depends on rclfp_pkg.
module rclfp_unpack #(
  parameter int unsigned NUM_CHANNELS = 13,
  parameter int unsigned AW           = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         slot_free_i,
  output logic                         busy_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_addr_o,
  input  logic [rclfp_pkg::BYTE_W-1:0] rd_data_i,
  output rclfp_pkg::ch_emit_t          emit_o
);
  import rclfp_pkg::*;

  localparam int unsigned CHAN_W = $clog2(NUM_CHANNELS + 1);

  logic                 busy_q, busy_d;
  logic                 pend_q, pend_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [ACC_CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [CHAN_W-1:0]    chan_q, chan_d;

  // Step: merge a fetched byte, fetch the next byte, or hand out a channel
  always_comb begin
    busy_d    = busy_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    chan_d    = chan_q;
    rd_en_o   = 1'b0;
    rd_addr_o = addr_q;
    emit_o    = '0;
    if (start_i) begin
      busy_d = 1'b1;
      pend_d = 1'b0;
      acc_d  = '0;
      cnt_d  = '0;
      addr_d = AW'(FIRST_CH_BYTE);
      chan_d = '0;
    end else if (busy_q) begin
      if (pend_q) begin
        acc_d  = acc_q | (ACC_W'(rd_data_i) << cnt_q);
        cnt_d  = cnt_q + ACC_CNT_W'(BYTE_W);
        pend_d = 1'b0;
      end else if (cnt_q < ACC_CNT_W'(CH_W)) begin
        rd_en_o = 1'b1;
        addr_d  = addr_q + AW'(1);
        pend_d  = 1'b1;
      end else if (slot_free_i) begin
        emit_o.valid = 1'b1;
        emit_o.index = CH_IDX_W'(chan_q);
        emit_o.value = acc_q[CH_W-1:0];
        emit_o.last  = (chan_q == CHAN_W'(NUM_CHANNELS - 1));
        acc_d        = acc_q >> CH_W;
        cnt_d        = cnt_q - ACC_CNT_W'(CH_W);
        chan_d       = chan_q + CHAN_W'(1);
        if (emit_o.last) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
      chan_q <= '0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      chan_q <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    addr_q <= addr_d;
  end

  assign busy_o = busy_q;

  // A fetch is only issued when fewer than a channel's bits are held
  a_pend_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cnt_q < ACC_CNT_W'(CH_W)))
    else $error("unpack: fetch outstanding with a full channel held");

  // The run ends on the channel flagged last
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(emit_o.valid && emit_o.last))
    else $error("unpack: run ended without last channel");

endmodule

### verif/testbench.sv
// Testbench for rc_link_frame_parser: random byte and tick streams against a built-in
// predictor of the frame parser, checked result by result. Depends on rclfp_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import rclfp_pkg::*;

  localparam int unsigned BUF_DEPTH    = 64;
  localparam int unsigned NUM_CHANNELS = 13;
  // Register index past the end of the map: writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {SEEK_SYNC, TAKE_LEN, COLLECT} parse_phase_e;

  typedef struct packed {
    logic                kind;
    logic [CH_IDX_W-1:0] index;
    logic [CH_W-1:0]     value;
    logic                last;
    logic                active;
    logic [CNT32_W-1:0]  resyncs;
  } report_t;

  // Predicts the parser and checks what comes out of it
  class rc_scoreboard;
    report_t             due_reports[$];
    int unsigned         failures;
    logic [BYTE_W-1:0]   start_byte;
    logic [LEN_W-1:0]    chan_len;
    logic [LEN_W-1:0]    max_len;
    parse_phase_e        phase;
    int unsigned         held;
    logic [LEN_W-1:0]    frame_len;
    logic [BYTE_W-1:0]   frame_bytes [BUF_DEPTH];
    logic [CNT32_W-1:0]  frames_since_tick;
    logic [CNT32_W-1:0]  resyncs;
    logic                active;

    function new();
      start_byte        = SYNC_RESET;
      chan_len          = CHFL_RESET;
      max_len           = MAXLEN_RESET;
      phase             = SEEK_SYNC;
      held              = 0;
      frame_len         = '0;
      frames_since_tick = '0;
      resyncs           = '0;
      active            = 1'b0;
      failures          = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
      case (idx)
        CFG_SYNC:   start_byte = v;
        CFG_CHFL:   chan_len   = v[LEN_W-1:0];
        CFG_MAXLEN: max_len    = v[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_report(logic kind, logic [CH_IDX_W-1:0] idx, logic [CH_W-1:0] val,
                              logic last);
      report_t r;
      r.kind    = kind;
      r.index   = idx;
      r.value   = val;
      r.last    = last;
      r.active  = active;
      r.resyncs = resyncs;
      due_reports.push_back(r);
    endfunction

    // 11-bit channel k, LSB first from the first channel byte on
    function logic [CH_W-1:0] channel_bits(int unsigned k);
      logic [CH_W-1:0] v;
      int unsigned     p;
      for (int unsigned i = 0; i < CH_W; i++) begin
        p    = FIRST_CH_BYTE * 8 + CH_W * k + i;
        v[i] = frame_bytes[p / 8][p % 8];
      end
      return v;
    endfunction

    // One accepted input transfer
    function void note_input(logic op, logic [BYTE_W-1:0] b);
      if (op == OP_TICK) begin
        if (frames_since_tick == 0) active = 1'b0;
        else frames_since_tick = '0;
        push_report(KIND_TICK, '0, '0, 1'b1);
        return;
      end
      // full store: wipe, count and rehunt with this same byte
      if (phase == COLLECT && held >= BUF_DEPTH) begin
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
        resyncs++;
        phase = SEEK_SYNC;
        held  = 0;
      end
      case (phase)
        SEEK_SYNC: begin
          if (b == start_byte) begin
            frame_bytes[0] = b;
            held  = 1;
            phase = TAKE_LEN;
          end
        end
        TAKE_LEN: begin
          if (b > {2'b00, max_len}) begin
            phase = SEEK_SYNC;
            held  = 0;
          end else begin
            frame_len      = b[LEN_W-1:0];
            frame_bytes[1] = b;
            held  = 2;
            phase = COLLECT;
          end
        end
        default: begin
          frame_bytes[held % BUF_DEPTH] = b;
          held++;
          if (held >= frame_len + 1) begin
            phase = SEEK_SYNC;
            held  = 0;
            if (frame_len == chan_len) begin
              frames_since_tick++;
              active = 1'b1;
              for (int unsigned k = 0; k < NUM_CHANNELS; k++)
                push_report(KIND_CHANNEL, k[CH_IDX_W-1:0], channel_bits(k),
                            k == NUM_CHANNELS - 1);
            end
          end
        end
      endcase
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
        failures++;
      end
    endfunction

    // One accepted result transfer
    function void check_result(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d index %0d value %0h",
                 $time, got.kind, got.index, got.value);
        failures++;
        return;
      end
      want = due_reports.pop_front();
      compare("kind", want.kind, got.kind);
      compare("channel_index", want.index, got.index);
      compare("channel_value", want.value, got.value);
      compare("last", want.last, got.last);
      compare("link_active", want.active, got.active);
      compare("resync_errors", want.resyncs, got.resyncs);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_op     = OP_BYTE;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 out_kind_o;
  logic [CH_IDX_W-1:0]  out_channel_index_o;
  logic [CH_W-1:0]      out_channel_value_o;
  logic                 out_last_o;
  logic                 out_link_active_o;
  logic [CNT32_W-1:0]   out_resync_errors_o;

  rc_scoreboard sb;
  int unsigned  burst_left = 0;
  int unsigned  items_sent = 0;

  rc_link_frame_parser #(
    .BUF_DEPTH   (BUF_DEPTH),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .in_op_i            (in_op),
    .in_data_byte_i     (in_byte),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .out_kind_o         (out_kind_o),
    .out_channel_index_o(out_channel_index_o),
    .out_channel_value_o(out_channel_value_o),
    .out_last_o         (out_last_o),
    .out_link_active_o  (out_link_active_o),
    .out_resync_errors_o(out_resync_errors_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: stall pattern redrawn each time stall_cyc wraps to zero, some windows never stall
  logic [15:0] stall_mask = 16'hFFFF;
  logic [5:0]  stall_cyc  = '0;
  always @(posedge clk_i) begin
    if (stall_cyc == 0)
      stall_mask <= ($urandom_range(2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    stall_cyc <= stall_cyc + 1'b1;
    out_ready <= stall_mask[stall_cyc[3:0]];
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready)
      sb.check_result(report_t'{out_kind_o, out_channel_index_o, out_channel_value_o,
                                out_last_o, out_link_active_o, out_resync_errors_o});
  end

  // One input transfer; the sender idles between bursts of random length
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(op, b);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(12, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_config(input logic [BYTE_W-1:0] s, input logic [LEN_W-1:0] c,
                             input logic [LEN_W-1:0] m);
    write_reg(CFG_SYNC, s);
    write_reg(CFG_CHFL, {2'b00, c});
    write_reg(CFG_MAXLEN, {2'b00, m});
    write_reg(CFG_UNUSED, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Idle input, wait for every result, then let the unpacker wind down
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] payload_byte();
    case ($urandom_range(7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sync, length and body; lengths mostly match the channel frame
  task automatic send_frame();
    logic [BYTE_W-1:0] len;
    int unsigned       body;
    int unsigned       roll;
    roll = $urandom_range(99);
    if (roll < 65)      len = {2'b00, sb.chan_len};
    else if (roll < 80) len = 8'($urandom_range(sb.max_len));
    else if (roll < 90) len = {2'b00, sb.max_len} + 8'd1;
    else                len = 8'($urandom);
    send_item(OP_BYTE, sb.start_byte);
    send_item(OP_BYTE, len);
    if (len > sb.max_len) return;
    body = (len > 1) ? len - 1 : 1;
    // truncated frame: the next sync lands in the body
    if ($urandom_range(9) == 0) body = $urandom_range(body - 1);
    for (int unsigned n = 0; n < body; n++) begin
      if ($urandom_range(15) == 0) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, payload_byte());
    end
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        send_item(OP_TICK, 8'($urandom));
      end else if (roll < 18) begin
        send_item(OP_BYTE, 8'($urandom));
        items_sent--;  // hunting noise does not count
      end else begin
        send_frame();
      end
    end
  endtask

  task automatic run_directed();
    send_item(OP_TICK, 8'hFF);        // no frame yet: link stays down
    send_item(OP_BYTE, 8'h00);        // noise while hunting
    send_item(OP_BYTE, SYNC_RESET);
    send_item(OP_BYTE, SYNC_RESET);   // length too big, not taken as a new sync
    send_item(OP_BYTE, 8'h18);        // ignored, hunting again
    // full channel frame; fills every byte the unpacker reads
    send_item(OP_BYTE, SYNC_RESET);
    send_item(OP_BYTE, 8'd24);
    for (int unsigned j = 2; j < 25; j++)
      send_item(OP_BYTE, (j < 10) ? 8'hFF : ((j < 20) ? 8'h00 : 8'h55));
    send_item(OP_TICK, 8'h00);        // frame seen: counter cleared, link up
    send_item(OP_TICK, 8'hA5);        // nothing since: link drops
    // zero length: completes on the first body byte
    send_item(OP_BYTE, SYNC_RESET);
    send_item(OP_BYTE, 8'd0);
    send_item(OP_BYTE, 8'h7F);
    // one past the length limit
    send_item(OP_BYTE, SYNC_RESET);
    send_item(OP_BYTE, 8'd49);
  endtask

  initial begin
    logic [BYTE_W-1:0] s;
    logic [LEN_W-1:0]  c;
    logic [LEN_W-1:0]  m;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_config(SYNC_RESET, CHFL_RESET, MAXLEN_RESET);
    run_directed();
    for (int unsigned round = 0; round < 5; round++) begin
      settle();
      case (round)
        0: begin s = 8'h00; c = 6'd0;  m = 6'd1;  end
        1: begin s = 8'hFF; c = 6'd48; m = 6'd48; end
        2: begin
          s = 8'($urandom);
          c = 6'($urandom_range(48));
          m = 6'($urandom_range(48, (c == 0) ? 1 : c));
        end
        3: begin s = 8'h5A; c = 6'd1;  m = 6'd10; end
        default: begin s = SYNC_RESET; c = CHFL_RESET; m = MAXLEN_RESET; end
      endcase
      load_config(s, c, m);
      run_random(45);
    end
    settle();
    if (sb.failures == 0) begin
      $display("** rc_link_frame_parser: PASSED **");
    end else begin
      $display("** rc_link_frame_parser: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** rc_link_frame_parser: FAILED **");
    $finish;
  end

endmodule
